@@ rtl/core/ppe_pkg.sv @@
// Package for the packed pixel palette expander.
// Holds the display mode codes and the per-mode pixel count lookup.
// No dependencies.
`default_nettype none

package ppe_pkg;

   typedef enum logic [2:0] {
      MODE_OFF       = 3'd0,
      MODE_RGB332_X1 = 3'd1,
      MODE_RGB332_X2 = 3'd2,
      MODE_RGB332_X4 = 3'd3,
      MODE_RGB121    = 3'd4,
      MODE_GREY4     = 3'd5,
      MODE_MONO      = 3'd6
   } mode_type;

   localparam logic [7:0] MONO_GREY = 8'hC0;

   // Index of the final pixel that one byte yields in the given mode.
   function automatic logic [2:0] last_index(input mode_type mode);
      logic [2:0] idx;
      idx = 3'd0;
      unique case (mode)
         MODE_RGB332_X1: idx = 3'd0;
         MODE_RGB332_X2: idx = 3'd1;
         MODE_RGB332_X4: idx = 3'd3;
         MODE_RGB121:    idx = 3'd1;
         MODE_GREY4:     idx = 3'd3;
         MODE_MONO:      idx = 3'd7;
         default:        idx = 3'd0;
      endcase
      return idx;
   endfunction

   // True when the mode produces any pixels at all.
   function automatic logic mode_active(input mode_type mode);
      logic act;
      act = 1'b0;
      unique case (mode)
         MODE_RGB332_X1, MODE_RGB332_X2, MODE_RGB332_X4,
         MODE_RGB121, MODE_GREY4, MODE_MONO: act = 1'b1;
         default: act = 1'b0;
      endcase
      return act;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/packed_pixel_palette_expander_unit.sv @@
// Top level of the packed pixel palette expander.
// Depends on ppe_pkg for mode codes and the pixel count lookup.
//
// Usage:
//   A byte of packed line-buffer data is taken as a transaction at a rising
//   edge where start is high and busy is low. The byte expands to 1, 2, 4 or
//   8 pixels depending on display_mode, or to none when the mode is off or
//   unused. Pixels leave on the rsp_ ports one per cycle, each marked by a
//   single-cycle rsp_valid strobe; rsp_last_pixel flags the final pixel of
//   the byte. The receiver cannot stall, so every strobe is a delivery.
//   The byte and pixel index are registered at the accepting edge, and each
//   pixel is registered again on the rsp_ ports. Throughput: one pixel per
//   cycle; a byte keeps the block busy until its final pixel (8 pixels in
//   monochrome, 1 in full-width 256-colour mode). The pixel counter is the
//   limiting element: busy drops during the final pixel of a byte, so the
//   next byte follows without a gap. The user must write the display_mode
//   register through csr_write_enable and csr_write_data while the block is
//   idle; the block itself does not enforce this. Reset (synchronous, active
//   high) clears the mode to off and drops any pixels in flight.
`default_nettype none

module packed_pixel_palette_expander_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_write_data,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [7:0] req_pixel_byte,
   output logic            rsp_valid,
   output logic [7:0]      rsp_red,
   output logic [7:0]      rsp_green,
   output logic [7:0]      rsp_blue,
   output logic            rsp_last_pixel
);
   import ppe_pkg::*;

   mode_type   mode_ff;
   mode_type   item_mode_ff;
   logic [7:0] byte_ff;
   logic [2:0] idx_ff;
   logic [2:0] last_ff;
   logic       active_ff;

   logic       accept;
   logic       at_last;
   logic [7:0] red_in, green_in, blue_in;
   logic [3:0] nibble;
   logic [1:0] grey;
   logic       rsp_valid_ff;
   logic [7:0] red_ff, green_ff, blue_ff;
   logic       last_pixel_ff;

   assign at_last = (idx_ff == last_ff);
   assign busy    = active_ff && !at_last;
   assign accept  = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
      end else if (csr_write_enable) begin
         mode_ff <= mode_type'(csr_write_data);
      end
   end

   // Input stage: holds the byte and walks the pixel index across it.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= 3'd0;
         last_ff   <= 3'd0;
      end else if (accept) begin
         active_ff <= mode_active(mode_ff);
         idx_ff    <= 3'd0;
         last_ff   <= last_index(mode_ff);
      end else if (busy) begin
         idx_ff    <= idx_ff + 3'd1;
      end else begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff      <= req_pixel_byte;
         item_mode_ff <= mode_ff;
      end
   end

   // Pixel formation for the current index.
   always_comb begin
      nibble   = idx_ff[0] ? byte_ff[7:4] : byte_ff[3:0];
      grey     = 2'(byte_ff >> {idx_ff[1:0], 1'b0});
      red_in   = 8'd0;
      green_in = 8'd0;
      blue_in  = 8'd0;
      unique case (item_mode_ff)
         MODE_RGB332_X1, MODE_RGB332_X2, MODE_RGB332_X4: begin
            red_in   = {byte_ff[7:5], 5'd0};
            green_in = {byte_ff[4:2], 5'd0};
            blue_in  = {byte_ff[1:0], 6'd0};
         end
         MODE_RGB121: begin
            red_in   = {nibble[3], 7'd0};
            green_in = {nibble[2:1], 6'd0};
            blue_in  = {nibble[0], 7'd0};
         end
         MODE_GREY4: begin
            red_in   = {grey, 6'd0};
            green_in = {grey, 6'd0};
            blue_in  = {grey, 6'd0};
         end
         MODE_MONO: begin
            red_in   = byte_ff[idx_ff] ? MONO_GREY : 8'd0;
            green_in = red_in;
            blue_in  = red_in;
         end
         default: begin
            red_in   = 8'd0;
            green_in = 8'd0;
            blue_in  = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      last_pixel_ff <= at_last;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_last_pixel = last_pixel_ff;

   // While a byte still has pixels left, the next cycle delivers one.
   assert_busy_delivers: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid)
      else $error("busy without a following pixel");

   // Pixels of one byte leave without gaps.
   assert_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_pixel) |=> rsp_valid)
      else $error("gap inside a byte's pixel run");

   // Grey and monochrome pixels carry equal components.
   assert_grey_equal: assert property (@(posedge clock) disable iff (reset)
      (active_ff && (item_mode_ff == MODE_GREY4 || item_mode_ff == MODE_MONO))
      |=> (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("grey pixel with unequal components");

   // A run never runs past its final index.
   assert_index_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= last_ff))
      else $error("pixel index beyond final pixel");

endmodule

`default_nettype wire
